>>> rtl/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Shared types, sizes and codes for the address region table unit.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int REGION_ENTRIES = 16;
    localparam int FLAG_BITS      = 8;
    localparam int ENTRY_W        = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;

    localparam int ADDR_W     = 32;
    localparam int FLAG_IO_W  = 8;
    localparam int INDEX_IO_W = 4;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_MODIFY = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_CONFLICT  = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic               load;
        logic               rd_en;
        logic [ENTRY_W-1:0] rd_addr;
        logic               finish;
    } cmd_t;

    function automatic logic [FLAG_BITS-1:0] flags_to_store(input logic [FLAG_IO_W-1:0] f);
        logic [31:0] wide;
        wide = 32'(f);
        return wide[FLAG_BITS-1:0];
    endfunction

    function automatic logic [FLAG_IO_W-1:0] flags_to_port(input logic [FLAG_BITS-1:0] f);
        logic [31:0] wide;
        wide = 32'(f);
        return wide[FLAG_IO_W-1:0];
    endfunction

    function automatic logic [INDEX_IO_W-1:0] index_to_port(input logic [ENTRY_W-1:0] i);
        logic [31:0] wide;
        wide = 32'(i);
        return wide[INDEX_IO_W-1:0];
    endfunction

    function automatic logic [ENTRY_W-1:0] index_from_port(input logic [INDEX_IO_W-1:0] i);
        logic [31:0] wide;
        wide = 32'(i);
        return wide[ENTRY_W-1:0];
    endfunction

endpackage

>>> rtl/art_ctrl.sv
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer: accepts an item, sweeps the table one entry per cycle, then
// tells the datapath to resolve and report the item.
// ----------------------------------------------------------------------------
module art_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output art_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [art_pkg::ENTRY_W-1:0] cnt_reg;
    logic [art_pkg::ENTRY_W-1:0] cnt_next;
    logic                        last_entry;

    assign last_entry = (cnt_reg == art_pkg::ENTRY_W'(art_pkg::REGION_ENTRIES - 1));
    assign busy       = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.load     = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.rd_addr  = cnt_reg;
        cmd.finish   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (last_entry)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && state_reg == S_SCAN && cnt_reg == '0))
        else $error("accepted item did not start a sweep");

    a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !cmd.finish && !busy)
        else $error("finish not a single cycle ending the item");

endmodule

>>> rtl/art_dp.sv
// ----------------------------------------------------------------------------
// art_dp
// Datapath: region table memory, valid bits, per-entry overlap and lookup
// compare, sweep accumulators and the registered result.
// ----------------------------------------------------------------------------
module art_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  art_pkg::cmd_t                    cmd,
    input  logic [1:0]                       mode,
    input  logic [art_pkg::ADDR_W-1:0]       start_addr,
    input  logic [art_pkg::ADDR_W-1:0]       end_addr,
    input  logic [art_pkg::FLAG_IO_W-1:0]    region_flags,
    input  logic [art_pkg::INDEX_IO_W-1:0]   entry_index,
    input  logic [art_pkg::ADDR_W-1:0]       lookup_addr,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [art_pkg::INDEX_IO_W-1:0]   result_index,
    output logic                             hit,
    output logic [art_pkg::ADDR_W-1:0]       out_start,
    output logic [art_pkg::ADDR_W-1:0]       out_end,
    output logic [art_pkg::FLAG_IO_W-1:0]    out_flags,
    output logic [art_pkg::ADDR_W-1:0]       out_size
);

    localparam int N  = art_pkg::REGION_ENTRIES;
    localparam int EW = art_pkg::ENTRY_W;
    localparam int AW = art_pkg::ADDR_W;
    localparam int FW = art_pkg::FLAG_BITS;

    logic [AW-1:0] start_mem [N];
    logic [AW-1:0] end_mem   [N];
    logic [FW-1:0] flags_mem [N];
    logic [N-1:0]  valid_reg;

    art_pkg::mode_t mode_reg;
    logic [AW-1:0]  s_reg;
    logic [AW-1:0]  e_reg;
    logic [FW-1:0]  f_reg;
    logic [EW-1:0]  idx_reg;
    logic           idx_range_reg;
    logic [AW-1:0]  la_reg;

    logic [AW-1:0]  rd_start_reg;
    logic [AW-1:0]  rd_end_reg;
    logic [FW-1:0]  rd_flags_reg;
    logic           rd_valid_reg;
    logic           cmp_valid_reg;
    logic [EW-1:0]  cmp_idx_reg;

    logic           conflict_reg;
    logic           free_found_reg;
    logic [EW-1:0]  free_idx_reg;
    logic           found_reg;
    logic [EW-1:0]  found_idx_reg;
    logic [AW-1:0]  found_start_reg;
    logic [AW-1:0]  found_end_reg;
    logic [FW-1:0]  found_flags_reg;

    logic           done_reg;
    art_pkg::status_t status_reg;
    logic [EW-1:0]  res_idx_reg;
    logic [AW-1:0]  res_start_reg;
    logic [AW-1:0]  res_end_reg;
    logic [FW-1:0]  res_flags_reg;

    logic           overlap;
    logic           skip_self;
    logic           lookup_match;
    logic           capture;
    logic           idx_ok;

    art_pkg::status_t res_status;
    logic [EW-1:0]  res_idx;
    logic [AW-1:0]  res_start;
    logic [AW-1:0]  res_end;
    logic [FW-1:0]  res_flags;
    logic           wr_en;
    logic [EW-1:0]  wr_idx;
    logic           clr_valid;

    assign overlap = (s_reg >= rd_start_reg && s_reg < rd_end_reg)
                  || (e_reg > rd_start_reg && e_reg <= rd_end_reg)
                  || (s_reg <= rd_start_reg && e_reg >= rd_end_reg);
    assign skip_self    = (mode_reg == art_pkg::MODE_MODIFY) && (cmp_idx_reg == idx_reg);
    assign lookup_match = rd_valid_reg && (la_reg >= rd_start_reg) && (la_reg < rd_end_reg);
    assign capture      = (mode_reg == art_pkg::MODE_LOOKUP) ? lookup_match
                        : ((mode_reg == art_pkg::MODE_DELETE) && (cmp_idx_reg == idx_reg));
    assign idx_ok       = idx_range_reg && valid_reg[idx_reg];

    // hold the item's fields for the sweep
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg      <= art_pkg::mode_t'(mode);
            s_reg         <= start_addr;
            e_reg         <= end_addr;
            f_reg         <= art_pkg::flags_to_store(region_flags);
            idx_reg       <= art_pkg::index_from_port(entry_index);
            idx_range_reg <= (32'(entry_index) < 32'(N));
            la_reg        <= lookup_addr;
        end
    end

    // table memory: one registered read, one write
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_start_reg <= start_mem[cmd.rd_addr];
            rd_end_reg   <= end_mem[cmd.rd_addr];
            rd_flags_reg <= flags_mem[cmd.rd_addr];
        end
        if (wr_en)
        begin
            start_mem[wr_idx] <= s_reg;
            end_mem[wr_idx]   <= e_reg;
            flags_mem[wr_idx] <= f_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.rd_en;
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (clr_valid)
            begin
                valid_reg[idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_valid_reg <= valid_reg[cmd.rd_addr];
            cmp_idx_reg  <= cmd.rd_addr;
        end
    end

    // accumulate sweep results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conflict_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else if (cmd.load)
        begin
            conflict_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else if (cmp_valid_reg)
        begin
            if (rd_valid_reg && !skip_self && overlap)
            begin
                conflict_reg <= 1'b1;
            end
            if (!rd_valid_reg && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (capture && !found_reg)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_valid_reg)
        begin
            if (!rd_valid_reg && !free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
            if (capture && !found_reg)
            begin
                found_idx_reg   <= cmp_idx_reg;
                found_start_reg <= rd_start_reg;
                found_end_reg   <= rd_end_reg;
                found_flags_reg <= rd_flags_reg;
            end
        end
    end

    // resolve the item at the end of the sweep
    always_comb
    begin
        res_status = art_pkg::STAT_OK;
        res_idx    = found_idx_reg;
        res_start  = found_start_reg;
        res_end    = found_end_reg;
        res_flags  = found_flags_reg;
        wr_en      = 1'b0;
        wr_idx     = idx_reg;
        clr_valid  = 1'b0;
        case (mode_reg)
            art_pkg::MODE_INSERT:
            begin
                res_idx   = free_idx_reg;
                res_start = s_reg;
                res_end   = e_reg;
                res_flags = f_reg;
                wr_idx    = free_idx_reg;
                if (conflict_reg)
                begin
                    res_status = art_pkg::STAT_CONFLICT;
                end
                else if (free_found_reg)
                begin
                    wr_en = cmd.finish;
                end
                else
                begin
                    res_status = art_pkg::STAT_FULL;
                end
            end
            art_pkg::MODE_LOOKUP:
            begin
                if (!found_reg)
                begin
                    res_status = art_pkg::STAT_NOT_FOUND;
                end
            end
            art_pkg::MODE_DELETE:
            begin
                if (idx_ok)
                begin
                    clr_valid = cmd.finish;
                end
                else
                begin
                    res_status = art_pkg::STAT_NOT_FOUND;
                end
            end
            art_pkg::MODE_MODIFY:
            begin
                res_idx   = idx_reg;
                res_start = s_reg;
                res_end   = e_reg;
                res_flags = f_reg;
                if (!idx_ok)
                begin
                    res_status = art_pkg::STAT_NOT_FOUND;
                end
                else if (conflict_reg)
                begin
                    res_status = art_pkg::STAT_CONFLICT;
                end
                else
                begin
                    wr_en = cmd.finish;
                end
            end
            default:
            begin
                res_status = art_pkg::STAT_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    // drop payload to zero on any failure
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= res_status;
            if (res_status == art_pkg::STAT_OK)
            begin
                res_idx_reg   <= res_idx;
                res_start_reg <= res_start;
                res_end_reg   <= res_end;
                res_flags_reg <= res_flags;
            end
            else
            begin
                res_idx_reg   <= '0;
                res_start_reg <= '0;
                res_end_reg   <= '0;
                res_flags_reg <= '0;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign result_index = art_pkg::index_to_port(res_idx_reg);
    assign hit          = (status_reg == art_pkg::STAT_OK);
    assign out_start    = res_start_reg;
    assign out_end      = res_end_reg;
    assign out_flags    = art_pkg::flags_to_port(res_flags_reg);
    assign out_size     = res_end_reg - res_start_reg;

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != art_pkg::STAT_OK) |->
            (result_index == '0 && out_start == '0 && out_end == '0 && out_flags == '0))
        else $error("failed item carries payload");

    a_write_no_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (cmd.finish && !conflict_reg))
        else $error("table written on conflict");

    a_delete_valid: assert property (@(posedge clk) disable iff (!rst_n)
        clr_valid |=> !valid_reg[$past(idx_reg)])
        else $error("deleted entry still valid");

    a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && mode_reg == art_pkg::MODE_INSERT) |-> !valid_reg[wr_idx])
        else $error("insert into occupied entry");

endmodule

>>> rtl/address_region_table_unit.sv
// ----------------------------------------------------------------------------
// address_region_table_unit
// Table of address regions with insert, lookup, delete and modify.
// ----------------------------------------------------------------------------
// An item is accepted when start is high and busy is low. Every item sweeps
// the whole table, one entry per cycle through the registered read port of
// the region memory. The last compare, the resolve step and the registered
// result follow the sweep, and done is registered together with the result.
// busy is low in the cycle that done is high, so the next item can be
// accepted at the edge that takes the result; an item is not accepted before
// the one ahead of it is through. done is high for exactly one cycle and the
// receiver cannot stall it.
// ----------------------------------------------------------------------------
module address_region_table_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       mode,
    input  logic [art_pkg::ADDR_W-1:0]       start_addr,
    input  logic [art_pkg::ADDR_W-1:0]       end_addr,
    input  logic [art_pkg::FLAG_IO_W-1:0]    region_flags,
    input  logic [art_pkg::INDEX_IO_W-1:0]   entry_index,
    input  logic [art_pkg::ADDR_W-1:0]       lookup_addr,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [art_pkg::INDEX_IO_W-1:0]   result_index,
    output logic                             hit,
    output logic [art_pkg::ADDR_W-1:0]       out_start,
    output logic [art_pkg::ADDR_W-1:0]       out_end,
    output logic [art_pkg::FLAG_IO_W-1:0]    out_flags,
    output logic [art_pkg::ADDR_W-1:0]       out_size
);

    art_pkg::cmd_t cmd;

    art_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    art_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (mode),
        .start_addr   (start_addr),
        .end_addr     (end_addr),
        .region_flags (region_flags),
        .entry_index  (entry_index),
        .lookup_addr  (lookup_addr),
        .done         (done),
        .status       (status),
        .result_index (result_index),
        .hit          (hit),
        .out_start    (out_start),
        .out_end      (out_end),
        .out_flags    (out_flags),
        .out_size     (out_size)
    );

endmodule

>>> bench/tb_address_region_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_address_region_table_unit
// Self-checking bench for the address region table unit.
// ----------------------------------------------------------------------------
// A directed table walks the empty table, the address extremes, the three
// overlap tests, empty and inverted ranges, conflicts and unknown entries.
// A random run of slot-based region sequences follows, with some noise, and
// keeps the table near full so that table-full results show up. Every item
// is predicted at acceptance and every done strobe is checked field by
// field against the oldest expected item.
// ----------------------------------------------------------------------------
module tb_address_region_table_unit;

    localparam int ENTRIES        = art_pkg::REGION_ENTRIES;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int LATENCY        = ENTRIES + 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT [4]   = '{0, 53, 0, 23};

    typedef struct packed {
        art_pkg::status_t stat;
        logic [3:0]       index;
        logic             hit;
        logic [31:0]      rstart;
        logic [31:0]      rend;
        logic [7:0]       flags;
        logic [31:0]      span;
    } region_result_t;

    typedef struct packed {
        art_pkg::mode_t op;
        logic [31:0]    s;
        logic [31:0]    e;
        logic [7:0]     f;
        logic [3:0]     idx;
        logic [31:0]    la;
        logic           typed;
        region_result_t want;
    } region_row_t;

    localparam region_result_t NO_ENTRY =
        '{art_pkg::STAT_NOT_FOUND, 4'd0, 1'b0, 32'd0, 32'd0, 8'd0, 32'd0};
    localparam region_result_t CLASH =
        '{art_pkg::STAT_CONFLICT, 4'd0, 1'b0, 32'd0, 32'd0, 8'd0, 32'd0};
    localparam region_result_t TABLE_FULL =
        '{art_pkg::STAT_FULL, 4'd0, 1'b0, 32'd0, 32'd0, 8'd0, 32'd0};

    localparam region_row_t DIRECTED [21] = '{
        '{art_pkg::MODE_LOOKUP, 32'h0, 32'h0, 8'h00, 4'd0, 32'h0, 1'b1, NO_ENTRY},
        '{art_pkg::MODE_DELETE, 32'h0, 32'h0, 8'h00, 4'd0, 32'h0, 1'b1, NO_ENTRY},
        '{art_pkg::MODE_MODIFY, 32'h1000, 32'h2000, 8'h11, 4'd15, 32'h0, 1'b1, NO_ENTRY},
        '{art_pkg::MODE_INSERT, 32'h0, 32'h100, 8'hFF, 4'd0, 32'h0, 1'b1,
          '{art_pkg::STAT_OK, 4'd0, 1'b1, 32'h0, 32'h100, 8'hFF, 32'h100}},
        '{art_pkg::MODE_INSERT, 32'hFFFF_FF00, 32'hFFFF_FFFF, 8'h00, 4'd0, 32'h0, 1'b1,
          '{art_pkg::STAT_OK, 4'd1, 1'b1, 32'hFFFF_FF00, 32'hFFFF_FFFF, 8'h00, 32'hFF}},
        '{art_pkg::MODE_INSERT, 32'h80, 32'h180, 8'h5A, 4'd0, 32'h0, 1'b1, CLASH},
        '{art_pkg::MODE_INSERT, 32'h100, 32'h200, 8'hA5, 4'd0, 32'h0, 1'b0, NO_ENTRY},
        '{art_pkg::MODE_INSERT, 32'h5000, 32'h4000, 8'h81, 4'd0, 32'h0, 1'b0, NO_ENTRY},
        '{art_pkg::MODE_INSERT, 32'h300, 32'h300, 8'h7E, 4'd0, 32'h0, 1'b0, NO_ENTRY},
        '{art_pkg::MODE_LOOKUP, 32'h0, 32'h0, 8'h00, 4'd0, 32'h0, 1'b0, NO_ENTRY},
        '{art_pkg::MODE_LOOKUP, 32'h0, 32'h0, 8'h00, 4'd0, 32'hFFFF_FFFE, 1'b0, NO_ENTRY},
        '{art_pkg::MODE_LOOKUP, 32'h0, 32'h0, 8'h00, 4'd0, 32'hFFFF_FFFF, 1'b1, NO_ENTRY},
        '{art_pkg::MODE_LOOKUP, 32'h0, 32'h0, 8'h00, 4'd0, 32'h300, 1'b0, NO_ENTRY},
        '{art_pkg::MODE_MODIFY, 32'h50, 32'h60, 8'h00, 4'd2, 32'h0, 1'b1, CLASH},
        '{art_pkg::MODE_MODIFY, 32'h180, 32'h280, 8'h3C, 4'd2, 32'h0, 1'b0, NO_ENTRY},
        '{art_pkg::MODE_DELETE, 32'h0, 32'h0, 8'h00, 4'd0, 32'h0, 1'b0, NO_ENTRY},
        '{art_pkg::MODE_DELETE, 32'h0, 32'h0, 8'h00, 4'd0, 32'h0, 1'b1, NO_ENTRY},
        '{art_pkg::MODE_INSERT, 32'h0, 32'h80, 8'hC3, 4'd0, 32'h0, 1'b0, NO_ENTRY},
        '{art_pkg::MODE_INSERT, 32'h0, 32'hFFFF_FFFF, 8'h01, 4'd0, 32'h0, 1'b1, CLASH},
        '{art_pkg::MODE_MODIFY, 32'hFFFF_FF00, 32'h0, 8'h42, 4'd1, 32'h0, 1'b0, NO_ENTRY},
        '{art_pkg::MODE_DELETE, 32'h0, 32'h0, 8'h00, 4'd3, 32'h0, 1'b0, NO_ENTRY}
    };

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic [1:0]                       mode;
    logic [art_pkg::ADDR_W-1:0]       start_addr;
    logic [art_pkg::ADDR_W-1:0]       end_addr;
    logic [art_pkg::FLAG_IO_W-1:0]    region_flags;
    logic [art_pkg::INDEX_IO_W-1:0]   entry_index;
    logic [art_pkg::ADDR_W-1:0]       lookup_addr;
    logic                             done;
    logic [1:0]                       status;
    logic [art_pkg::INDEX_IO_W-1:0]   result_index;
    logic                             hit;
    logic [art_pkg::ADDR_W-1:0]       out_start;
    logic [art_pkg::ADDR_W-1:0]       out_end;
    logic [art_pkg::FLAG_IO_W-1:0]    out_flags;
    logic [art_pkg::ADDR_W-1:0]       out_size;

    logic [31:0]             rg_start [ENTRIES];
    logic [31:0]             rg_end   [ENTRIES];
    logic [7:0]              rg_flags [ENTRIES];
    bit                      live     [ENTRIES];

    region_result_t          region_q [$];
    region_result_t          oldest;
    int                      errors;
    int                      results_seen;
    int                      quiet_cycles;

    address_region_table_unit u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .start_addr   (start_addr),
        .end_addr     (end_addr),
        .region_flags (region_flags),
        .entry_index  (entry_index),
        .lookup_addr  (lookup_addr),
        .done         (done),
        .status       (status),
        .result_index (result_index),
        .hit          (hit),
        .out_start    (out_start),
        .out_end      (out_end),
        .out_flags    (out_flags),
        .out_size     (out_size)
    );

    always #5 clk = ~clk;

    function automatic bit range_clashes(logic [31:0] s, logic [31:0] e, int skip);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (live[i] && i != skip)
            begin
                if (s >= rg_start[i] && s < rg_end[i])
                    return 1'b1;
                if (e > rg_start[i] && e <= rg_end[i])
                    return 1'b1;
                if (s <= rg_start[i] && e >= rg_end[i])
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic region_result_t apply_region_op(art_pkg::mode_t op, logic [31:0] s,
                                                       logic [31:0] e, logic [7:0] f,
                                                       logic [3:0] idx, logic [31:0] la);
        region_result_t r;
        int             slot;
        r    = NO_ENTRY;
        slot = -1;
        case (op)
            art_pkg::MODE_INSERT:
            begin
                if (range_clashes(s, e, -1))
                    r = CLASH;
                else
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (!live[i] && slot < 0)
                            slot = i;
                    if (slot < 0)
                        r = TABLE_FULL;
                    else
                    begin
                        rg_start[slot] = s;
                        rg_end[slot]   = e;
                        rg_flags[slot] = f;
                        live[slot]     = 1'b1;
                    end
                end
            end
            art_pkg::MODE_LOOKUP:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && live[i] && la >= rg_start[i] && la < rg_end[i])
                        slot = i;
            end
            art_pkg::MODE_DELETE:
            begin
                if (live[idx])
                begin
                    slot      = int'(idx);
                    live[idx] = 1'b0;
                end
            end
            default:
            begin
                if (live[idx])
                begin
                    if (range_clashes(s, e, int'(idx)))
                        r = CLASH;
                    else
                    begin
                        slot          = int'(idx);
                        rg_start[idx] = s;
                        rg_end[idx]   = e;
                        rg_flags[idx] = f;
                    end
                end
            end
        endcase
        if (slot >= 0)
            r = '{art_pkg::STAT_OK, 4'(slot), 1'b1, rg_start[slot], rg_end[slot],
                  rg_flags[slot], rg_end[slot] - rg_start[slot]};
        return r;
    endfunction

    function automatic logic [3:0] pick_live_entry();
        int k;
        k = $urandom_range(0, ENTRIES - 1);
        for (int n = 0; n < ENTRIES; n++)
            if (live[(k + n) % ENTRIES])
                return 4'((k + n) % ENTRIES);
        return 4'(k);
    endfunction

    task automatic build_random_item(output art_pkg::mode_t op, output logic [31:0] s,
                                     output logic [31:0] e, output logic [7:0] f,
                                     output logic [3:0] idx, output logic [31:0] la);
        int          r;
        int          live_n;
        int          insert_cut;
        logic [31:0] base;
        live_n = 0;
        for (int i = 0; i < ENTRIES; i++)
            live_n += int'(live[i]);
        base = 32'($urandom_range(0, 20)) * 32'h0C00_0000;
        s    = base + 32'($urandom_range(0, 32'h03FF_FFFF));
        e    = s + 32'($urandom_range(1, 32'h0400_0000));
        f    = 8'($urandom);
        idx  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : pick_live_entry();
        la   = $urandom;
        r    = $urandom_range(0, 99);
        if (r < 8)
        begin
            op = art_pkg::mode_t'($urandom_range(0, 3));
            s  = $urandom;
            e  = $urandom;
        end
        else
        begin
            insert_cut = (live_n >= 14) ? 25 : 40;
            r = $urandom_range(0, 99);
            if (r < insert_cut)
                op = art_pkg::MODE_INSERT;
            else if (r < insert_cut + 30)
                op = art_pkg::MODE_LOOKUP;
            else if (r < 80)
                op = art_pkg::MODE_DELETE;
            else
                op = art_pkg::MODE_MODIFY;
            if (op == art_pkg::MODE_LOOKUP && live[idx] && rg_start[idx] < rg_end[idx]
                && $urandom_range(0, 4) != 0)
            begin
                case ($urandom_range(0, 3))
                    0:       la = rg_start[idx];
                    1:       la = rg_end[idx] - 32'd1;
                    2:       la = rg_end[idx];
                    default: la = rg_start[idx] + $urandom % (rg_end[idx] - rg_start[idx]);
                endcase
            end
        end
    endtask

    task automatic issue_item(art_pkg::mode_t op, logic [31:0] s, logic [31:0] e,
                              logic [7:0] f, logic [3:0] idx, logic [31:0] la, bit typed,
                              region_result_t want, int idle_pct);
        region_result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        mode         <= op;
        start_addr   <= s;
        end_addr     <= e;
        region_flags <= f;
        entry_index  <= idx;
        lookup_addr  <= la;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_region_op(op, s, e, f, idx, la);
        region_q.push_back(typed ? want : predicted);
    endtask

    task automatic report_mismatch(string what);
        $display("%0t result %0d mismatch: %s", $time, results_seen, what);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (done)
        begin
            results_seen++;
            if (region_q.size() == 0)
                report_mismatch("result with no item outstanding");
            else
            begin
                oldest = region_q.pop_front();
                if (status !== oldest.stat)
                    report_mismatch($sformatf("status %0d, want %0d", status, oldest.stat));
                if (result_index !== oldest.index)
                    report_mismatch($sformatf("result_index %0d, want %0d",
                                              result_index, oldest.index));
                if (hit !== oldest.hit)
                    report_mismatch($sformatf("hit %b, want %b", hit, oldest.hit));
                if (out_start !== oldest.rstart)
                    report_mismatch($sformatf("out_start %h, want %h",
                                              out_start, oldest.rstart));
                if (out_end !== oldest.rend)
                    report_mismatch($sformatf("out_end %h, want %h", out_end, oldest.rend));
                if (out_flags !== oldest.flags)
                    report_mismatch($sformatf("out_flags %h, want %h",
                                              out_flags, oldest.flags));
                if (out_size !== oldest.span)
                    report_mismatch($sformatf("out_size %h, want %h", out_size, oldest.span));
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        art_pkg::mode_t op;
        logic [31:0]    s;
        logic [31:0]    e;
        logic [31:0]    la;
        logic [7:0]     f;
        logic [3:0]     idx;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        mode         = art_pkg::MODE_INSERT;
        start_addr   = '0;
        end_addr     = '0;
        region_flags = '0;
        entry_index  = '0;
        lookup_addr  = '0;
        errors       = 0;
        results_seen = 0;
        for (int i = 0; i < ENTRIES; i++)
            live[i] = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[k])
            issue_item(DIRECTED[k].op, DIRECTED[k].s, DIRECTED[k].e, DIRECTED[k].f,
                       DIRECTED[k].idx, DIRECTED[k].la, DIRECTED[k].typed,
                       DIRECTED[k].want, 0);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 2)
            begin
                // hold off until the table has answered every item
                @(negedge clk);
                start <= 1'b0;
                while (region_q.size() != 0)
                    @(posedge clk);
            end
            build_random_item(op, s, e, f, idx, la);
            issue_item(op, s, e, f, idx, la, 1'b0, NO_ENTRY,
                       IDLE_PCT[k * 4 / RANDOM_ITEMS]);
        end
        @(negedge clk);
        start <= 1'b0;

        while (region_q.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
